FILE: hdl/i2cram_pkg.sv
// i2cram_pkg: shared types and constants of the i2c register access master
// used by the front queue, the bus engine, the result queue and the top level
`default_nettype none

package i2cram_pkg;

  localparam logic [7:0]  DevWrMask     = 8'hfe;
  localparam logic [7:0]  DevRdBit      = 8'h01;
  localparam logic [7:0]  MsbMask       = 8'h80;
  localparam logic [7:0]  HalfPeriodRst = 8'd10;
  localparam logic [15:0] AckTimeoutRst = 16'd1000;
  localparam int          ItemDepthDef  = 2;
  localparam int          ResDepthDef   = 2;
  localparam int          AddrW         = 3;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_BEGIN  = 2'd1,
    REQ_SUPPLY = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_e;

  typedef enum logic {
    REG_HALF_PERIOD = 1'b0,
    REG_ACK_TIMEOUT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  half_period;
    logic [15:0] ack_timeout;
  } cfg_t;

  typedef struct packed {
    req_kind_e  kind;
    logic       sda_in;
    logic       is_read;
    logic [7:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] length;
    logic [7:0] wr_byte;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic [7:0] rd_byte;
    logic       rd_valid;
    logic       rd_last;
    logic       byte_wanted;
    logic       busy;
    logic       done;
    logic       status;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/i2cram_front.sv
// i2cram_front: accepts request beats, classifies them and queues them for the engine
// depends on i2cram_pkg
`default_nettype none

module i2cram_front
  import i2cram_pkg::*;
#(
  parameter int Depth = ItemDepthDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic       sda_in_i,
  input  wire logic       is_read_i,
  input  wire logic [7:0] dev_addr_i,
  input  wire logic [7:0] reg_addr_i,
  input  wire logic [7:0] length_i,
  input  wire logic [7:0] wr_byte_i,
  output logic            item_valid_o,
  output item_t           item_o,
  input  wire logic       item_take_i
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;
  item_t            item_new;
  req_kind_e        kind;

  assign kind = req_kind_e'(req_type_i);

  assign item_new = '{kind: kind, sda_in: sda_in_i, is_read: is_read_i,
                      dev_addr: dev_addr_i, reg_addr: reg_addr_i,
                      length: length_i, wr_byte: wr_byte_i};

  assign full_o       = (cnt_q == CntW'(Depth));
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign wr_en        = push_i && !full_o;
  assign rd_en        = item_take_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/i2cram_res_fifo.sv
// i2cram_res_fifo: result queue between the bus engine and the result port
// depends on i2cram_pkg
`default_nettype none

module i2cram_res_fifo
  import i2cram_pkg::*;
#(
  parameter int Depth = ResDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  res_t      data_i,
  output logic      ready_o,
  output logic      empty_o,
  input  wire logic pop_i,
  output res_t      data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  res_t             mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign empty_o = (cnt_q == '0);
  assign rd_en   = pop_i && !empty_o;
  assign ready_o = (cnt_q != CntW'(Depth)) || rd_en;
  assign wr_en   = push_i && ready_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/i2cram_engine.sv
// i2cram_engine: bus phase sequencer that carries out one queued request per cycle
// while the result queue has room; depends on i2cram_pkg; feeds i2cram_res_fifo
`default_nettype none

module i2cram_engine
  import i2cram_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  cfg_t      cfg_i,
  input  wire logic item_valid_i,
  input  item_t     item_i,
  output logic      item_take_o,
  input  wire logic res_ready_i,
  output logic      res_push_o,
  output res_t      res_o
);

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_ST_A      = 5'd1,
    PH_ST_B      = 5'd2,
    PH_RS_PRE    = 5'd3,
    PH_TX_SETUP  = 5'd4,
    PH_TX_HIGH   = 5'd5,
    PH_TX_LOW    = 5'd6,
    PH_ACK_SETUP = 5'd7,
    PH_ACK_HIGH  = 5'd8,
    PH_ACK_WAIT  = 5'd9,
    PH_DATA_WAIT = 5'd10,
    PH_RX_LOW    = 5'd11,
    PH_RX_HIGH   = 5'd12,
    PH_MA_SETUP  = 5'd13,
    PH_MA_HIGH   = 5'd14,
    PH_MA_LOW    = 5'd15,
    PH_STOP_PRE  = 5'd16,
    PH_STOP_A    = 5'd17
  } phase_e;

  typedef enum logic [1:0] {
    STG_DEV   = 2'd0,
    STG_REG   = 2'd1,
    STG_DEVRD = 2'd2,
    STG_DATA  = 2'd3
  } stage_e;

  phase_e      phase_q, phase_d, nxt;
  stage_e      stage_q, stage_d;
  logic [7:0]  timer_q, timer_d;
  logic [15:0] ack_q, ack_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic        rmode_q, rmode_d;
  logic [7:0]  hbyte_q, hbyte_d;
  logic        hfull_q, hfull_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        nack_q, nack_d;
  logic        go, el;
  logic [7:0]  hp, tn;
  res_t        res_d;

  function automatic logic [1:0] drive_of(phase_e p, logic [7:0] sh, logic [7:0] left);
    logic       tx;
    logic       ma;
    logic [1:0] r;
    tx = ((sh & MsbMask) != 8'h00);
    ma = (left == 8'h00);
    case (p)
      PH_ST_B:      r = 2'b10;
      PH_RS_PRE:    r = 2'b01;
      PH_TX_SETUP:  r = {1'b0, tx};
      PH_TX_HIGH:   r = {1'b1, tx};
      PH_TX_LOW:    r = {1'b0, tx};
      PH_ACK_SETUP: r = 2'b01;
      PH_DATA_WAIT: r = 2'b01;
      PH_RX_LOW:    r = 2'b01;
      PH_MA_SETUP:  r = {1'b0, ma};
      PH_MA_HIGH:   r = {1'b1, ma};
      PH_MA_LOW:    r = {1'b0, ma};
      PH_STOP_PRE:  r = 2'b00;
      PH_STOP_A:    r = 2'b10;
      default:      r = 2'b11;
    endcase
    return r;
  endfunction

  assign item_take_o = item_valid_i && res_ready_i;
  assign res_push_o  = item_take_o;
  assign res_o       = res_d;

  // phase timing, zero half period counts as one tick
  assign hp = (cfg_i.half_period == 8'd0) ? 8'd1 : cfg_i.half_period;
  assign tn = timer_q + 8'd1;
  assign el = ({1'b0, timer_q} + 9'd1) >= {1'b0, hp};

  always_comb begin
    phase_d = phase_q;
    stage_d = stage_q;
    timer_d = timer_q;
    ack_d   = ack_q;
    bit_d   = bit_q;
    left_d  = left_q;
    shift_d = shift_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    rmode_d = rmode_q;
    hbyte_d = hbyte_q;
    hfull_d = hfull_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    nack_d  = nack_q;
    go      = 1'b0;
    nxt     = PH_IDLE;
    res_d   = '0;
    if (item_take_o) begin
      case (item_i.kind)
        REQ_BEGIN: begin
          if (phase_q == PH_IDLE) begin
            rmode_d = item_i.is_read;
            dev_d   = item_i.dev_addr;
            reg_d   = item_i.reg_addr;
            left_d  = item_i.length;
            hfull_d = 1'b0;
            nack_d  = 1'b0;
            ack_d   = '0;
            stage_d = STG_DEV;
            bit_d   = '0;
            shift_d = item_i.is_read ? (item_i.dev_addr & DevWrMask) : item_i.dev_addr;
            go      = 1'b1;
            nxt     = PH_ST_A;
          end
        end
        REQ_SUPPLY: begin
          if (phase_q != PH_IDLE && !rmode_q && !hfull_q && left_q != 8'd0) begin
            hbyte_d = item_i.wr_byte;
            hfull_d = 1'b1;
          end
        end
        REQ_TICK: begin
          if (phase_q != PH_IDLE) begin
            case (phase_q)
              PH_ST_A: begin
                timer_d = tn;
                go      = el;
                nxt     = PH_ST_B;
              end
              PH_ST_B: begin
                timer_d = tn;
                if (el) begin
                  bit_d = '0;
                  go    = 1'b1;
                  nxt   = PH_TX_SETUP;
                end
              end
              PH_RS_PRE: begin
                timer_d = tn;
                go      = el;
                nxt     = PH_ST_A;
              end
              PH_TX_SETUP: begin
                timer_d = tn;
                go      = el;
                nxt     = PH_TX_HIGH;
              end
              PH_TX_HIGH: begin
                timer_d = tn;
                go      = el;
                nxt     = PH_TX_LOW;
              end
              PH_TX_LOW: begin
                timer_d = tn;
                if (el) begin
                  shift_d = {shift_q[6:0], 1'b0};
                  bit_d   = bit_q + 4'd1;
                  go      = 1'b1;
                  nxt     = (bit_d >= 4'd8) ? PH_ACK_SETUP : PH_TX_SETUP;
                end
              end
              PH_ACK_SETUP: begin
                timer_d = tn;
                go      = el;
                nxt     = PH_ACK_HIGH;
              end
              PH_ACK_HIGH: begin
                timer_d = tn;
                if (el) begin
                  ack_d = '0;
                  go    = 1'b1;
                  nxt   = PH_ACK_WAIT;
                end
              end
              PH_ACK_WAIT: begin
                if (!item_i.sda_in) begin
                  go = 1'b1;
                  case (stage_q)
                    STG_DEV: begin
                      stage_d = STG_REG;
                      shift_d = reg_q;
                      bit_d   = '0;
                      nxt     = PH_TX_SETUP;
                    end
                    STG_REG: begin
                      if (rmode_q) begin
                        stage_d = STG_DEVRD;
                        shift_d = dev_q | DevRdBit;
                        nxt     = PH_RS_PRE;
                      end else begin
                        stage_d = STG_DATA;
                        nxt     = PH_DATA_WAIT;
                      end
                    end
                    STG_DEVRD: begin
                      stage_d = STG_DATA;
                      if (left_q == 8'd0) begin
                        nxt = PH_STOP_PRE;
                      end else begin
                        shift_d = '0;
                        bit_d   = '0;
                        nxt     = PH_RX_LOW;
                      end
                    end
                    default: begin
                      nxt = PH_DATA_WAIT;
                    end
                  endcase
                end else if (ack_q >= cfg_i.ack_timeout) begin
                  nack_d = 1'b1;
                  go     = 1'b1;
                  nxt    = PH_STOP_PRE;
                end else begin
                  ack_d = ack_q + 16'd1;
                end
              end
              PH_DATA_WAIT: begin
                if (left_q == 8'd0) begin
                  go  = 1'b1;
                  nxt = PH_STOP_PRE;
                end else if (hfull_q) begin
                  hfull_d = 1'b0;
                  left_d  = left_q - 8'd1;
                  shift_d = hbyte_q;
                  bit_d   = '0;
                  go      = 1'b1;
                  nxt     = PH_TX_SETUP;
                end
              end
              PH_RX_LOW: begin
                timer_d = tn;
                go      = el;
                nxt     = PH_RX_HIGH;
              end
              PH_RX_HIGH: begin
                timer_d = tn;
                if (el) begin
                  shift_d = {shift_q[6:0], item_i.sda_in};
                  bit_d   = bit_q + 4'd1;
                  go      = 1'b1;
                  if (bit_d >= 4'd8) begin
                    res_d.rd_byte  = shift_d;
                    res_d.rd_valid = 1'b1;
                    res_d.rd_last  = (left_q <= 8'd1);
                    left_d         = (left_q == 8'd0) ? 8'd0 : left_q - 8'd1;
                    nxt            = PH_MA_SETUP;
                  end else begin
                    nxt = PH_RX_LOW;
                  end
                end
              end
              PH_MA_SETUP: begin
                timer_d = tn;
                go      = el;
                nxt     = PH_MA_HIGH;
              end
              PH_MA_HIGH: begin
                timer_d = tn;
                go      = el;
                nxt     = PH_MA_LOW;
              end
              PH_MA_LOW: begin
                timer_d = tn;
                if (el) begin
                  go = 1'b1;
                  if (left_q == 8'd0) begin
                    nxt = PH_STOP_PRE;
                  end else begin
                    shift_d = '0;
                    bit_d   = '0;
                    nxt     = PH_RX_LOW;
                  end
                end
              end
              PH_STOP_PRE: begin
                timer_d = tn;
                go      = el;
                nxt     = PH_STOP_A;
              end
              PH_STOP_A: begin
                timer_d = tn;
                if (el) begin
                  res_d.done   = 1'b1;
                  res_d.status = nack_q;
                  hfull_d      = 1'b0;
                  go           = 1'b1;
                  nxt          = PH_IDLE;
                end
              end
              default: begin
                go  = 1'b1;
                nxt = PH_IDLE;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
      if (go) begin
        phase_d        = nxt;
        timer_d        = '0;
        {scl_d, sda_d} = drive_of(nxt, shift_d, left_d);
      end
    end
    res_d.scl_level   = scl_d;
    res_d.sda_level   = sda_d;
    res_d.byte_wanted = (phase_d != PH_IDLE) && !rmode_d && !hfull_d && (left_d != 8'd0);
    res_d.busy        = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      stage_q <= STG_DEV;
      timer_q <= '0;
      ack_q   <= '0;
      bit_q   <= '0;
      left_q  <= '0;
      shift_q <= '0;
      dev_q   <= '0;
      reg_q   <= '0;
      rmode_q <= 1'b0;
      hbyte_q <= '0;
      hfull_q <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      nack_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      stage_q <= stage_d;
      timer_q <= timer_d;
      ack_q   <= ack_d;
      bit_q   <= bit_d;
      left_q  <= left_d;
      shift_q <= shift_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      rmode_q <= rmode_d;
      hbyte_q <= hbyte_d;
      hfull_q <= hfull_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      nack_q  <= nack_d;
    end
  end

`ifndef SYNTHESIS
  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_take_o && res_d.done) |=> (phase_q == PH_IDLE))
    else $error("done reported but engine not idle");

  a_rd_only_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_take_o && res_d.rd_valid) |-> rmode_q)
    else $error("received byte outside a read");

  a_no_hold_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hfull_q && rmode_q))
    else $error("write byte held during a read");

  a_leave_busy_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_take_o && item_i.kind == REQ_TICK && phase_q != PH_IDLE && !res_d.busy)
      |-> res_d.done)
    else $error("transfer ended without done");
`endif

endmodule

`default_nettype wire

FILE: hdl/i2c_register_access_master_top.sv
// i2c_register_access_master_top: configuration registers and the request/result queues
// depends on i2cram_pkg, i2cram_front, i2cram_engine, i2cram_res_fifo
//
// Usage: request beats are pushed while full is low. req_type selects a bus tick with the
// sampled SDA level, a begin (is_read, dev_addr, reg_addr, length) or a write data byte.
// Every request beat yields exactly one result beat, read while empty is low and taken
// with pop: SCL and SDA drive levels, received byte with valid and last flags, byte_wanted,
// busy, and done with status (1 when the slave failed to acknowledge).
// Each tick beat advances the bus sequencer by one step; a bus phase lasts
// half_period_ticks tick beats, the acknowledge wait up to ack_timeout_ticks + 1 beats.
// Throughput is one request per cycle while the result queue has room. A result is written
// into the result queue as its request is accepted and is on the result ports at its head.
// Registers (APB, byte addresses): 0x0 half_period_ticks, 0x4 ack_timeout_ticks;
// write them only while no transfer is running.
// Reset clears both queues, idles the bus with SCL and SDA released and loads the
// register defaults of 10 and 1000. When pop stays low the result queue fills, the
// sequencer holds and the request queue raises full once it is full too.
`default_nettype none

module i2c_register_access_master_top
  import i2cram_pkg::*;
#(
  parameter int ItemDepth = ItemDepthDef,
  parameter int ResDepth  = ResDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [1:0]       req_type_i,
  input  wire logic             sda_in_i,
  input  wire logic             is_read_i,
  input  wire logic [7:0]       dev_addr_i,
  input  wire logic [7:0]       reg_addr_i,
  input  wire logic [7:0]       length_i,
  input  wire logic [7:0]       wr_byte_i,
  output logic                  empty,
  input  wire logic             pop,
  output logic                  scl_level_o,
  output logic                  sda_level_o,
  output logic [7:0]            rd_byte_o,
  output logic                  rd_valid_o,
  output logic                  rd_last_o,
  output logic                  byte_wanted_o,
  output logic                  busy_res_o,
  output logic                  done_res_o,
  output logic                  status_o
);

  cfg_t     cfg_q, cfg_d;
  cfg_reg_e reg_sel;
  logic     cfg_wr;
  logic     item_valid, item_take;
  item_t    item;
  logic     res_ready, res_push;
  res_t     res_in, res_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = cfg_reg_e'(paddr[2]);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_sel)
        REG_HALF_PERIOD: cfg_d.half_period = pwdata[7:0];
        REG_ACK_TIMEOUT: cfg_d.ack_timeout = pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_HALF_PERIOD: prdata = {24'd0, cfg_q.half_period};
      REG_ACK_TIMEOUT: prdata = {16'd0, cfg_q.ack_timeout};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{half_period: HalfPeriodRst, ack_timeout: AckTimeoutRst};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  i2cram_front #(
    .Depth (ItemDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .req_type_i   (req_type_i),
    .sda_in_i     (sda_in_i),
    .is_read_i    (is_read_i),
    .dev_addr_i   (dev_addr_i),
    .reg_addr_i   (reg_addr_i),
    .length_i     (length_i),
    .wr_byte_i    (wr_byte_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_take_i  (item_take)
  );

  i2cram_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_take_o  (item_take),
    .res_ready_i  (res_ready),
    .res_push_o   (res_push),
    .res_o        (res_in)
  );

  i2cram_res_fifo #(
    .Depth (ResDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .ready_o (res_ready),
    .empty_o (empty),
    .pop_i   (pop),
    .data_o  (res_out)
  );

  assign scl_level_o   = res_out.scl_level;
  assign sda_level_o   = res_out.sda_level;
  assign rd_byte_o     = res_out.rd_byte;
  assign rd_valid_o    = res_out.rd_valid;
  assign rd_last_o     = res_out.rd_last;
  assign byte_wanted_o = res_out.byte_wanted;
  assign busy_res_o    = res_out.busy;
  assign done_res_o    = res_out.done;
  assign status_o      = res_out.status;

endmodule

`default_nettype wire
